// ===== hw/rtl/led64_block_decrypt_unit_assert.svh =====
// assertion macros used by the checker file of the led64 decrypt unit
// depends on nothing; included by the checker module
`ifndef LED64_BLOCK_DECRYPT_UNIT_ASSERT_SVH
`define LED64_BLOCK_DECRYPT_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LED64_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define LED64_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/led64_pkg.sv =====
// constants, tables and round function of the led-64 inverse cipher
// depends on nothing; imported by led64_round and the top level
`timescale 1ns / 1ps

package led64_pkg;

    localparam int KEY_BITS        = 64;
    localparam int ROUNDS          = 32;
    localparam int ROUNDS_PER_STEP = 4;

    localparam logic [4:0] FIRST_ROUND = 5'd0;
    localparam logic [1:0] STEP_LAST   = 2'(ROUNDS_PER_STEP - 1);

    // key-size constants
    localparam logic [3:0] KS_HI = 4'((KEY_BITS / 16) % 16);
    localparam logic [3:0] KS_LO = 4'(KEY_BITS % 16);

    localparam logic [3:0] INV_SBOX [16] = '{
        4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
        4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
    };

    localparam logic [5:0] ROUND_CONST [32] = '{
        6'h01, 6'h03, 6'h07, 6'h0F, 6'h1F, 6'h3E, 6'h3D, 6'h3B,
        6'h37, 6'h2F, 6'h1E, 6'h3C, 6'h39, 6'h33, 6'h27, 6'h0E,
        6'h1D, 6'h3A, 6'h35, 6'h2B, 6'h16, 6'h2C, 6'h18, 6'h30,
        6'h21, 6'h02, 6'h05, 6'h0B, 6'h17, 6'h2E, 6'h1C, 6'h38
    };

    localparam logic [3:0] INV_MDS [4][4] = '{
        '{4'hC, 4'hC, 4'hD, 4'h4},
        '{4'h3, 4'h8, 4'h4, 4'h5},
        '{4'h7, 4'h6, 4'h2, 4'hE},
        '{4'hD, 4'h9, 4'h9, 4'hD}
    };

    // multiply in gf(16), polynomial x^4+x+1
    function automatic logic [3:0] gf16_mul(input logic [3:0] a, input logic [3:0] b);
        logic [3:0] r;
        logic [3:0] x;
        r = 4'h0;
        x = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) begin
                r = r ^ x;
            end
            x = {x[2:0], 1'b0} ^ (x[3] ? 4'h3 : 4'h0);
        end
        return r;
    endfunction

    // one inverse round: mixcolumns with shiftrows, s-box, constants
    function automatic logic [63:0] inv_round(input logic [63:0] s, input logic [4:0] rnd);
        logic [3:0] t [16];
        logic [3:0] acc;
        logic [5:0] rc;
        logic [63:0] o;
        for (int col = 0; col < 4; col++) begin
            for (int row = 0; row < 4; row++) begin
                acc = 4'h0;
                for (int k = 0; k < 4; k++) begin
                    acc = acc ^ gf16_mul(INV_MDS[row][k], s[4*(4*k+col) +: 4]);
                end
                t[row*4 + ((col + row) % 4)] = acc;
            end
        end
        for (int n = 0; n < 16; n++) begin
            o[4*n +: 4] = INV_SBOX[t[n]];
        end
        // constant index runs backwards from the last round
        rc = ROUND_CONST[~rnd];
        o[3:0]   = o[3:0]   ^ KS_HI;
        o[19:16] = o[19:16] ^ (4'h1 ^ KS_HI);
        o[35:32] = o[35:32] ^ (4'h2 ^ KS_LO);
        o[51:48] = o[51:48] ^ (4'h3 ^ KS_LO);
        o[7:4]   = o[7:4]   ^ {1'b0, rc[5:3]};
        o[39:36] = o[39:36] ^ {1'b0, rc[5:3]};
        o[23:20] = o[23:20] ^ {1'b0, rc[2:0]};
        o[55:52] = o[55:52] ^ {1'b0, rc[2:0]};
        return o;
    endfunction

endpackage

// ===== hw/rtl/led64_block_decrypt_unit.sv =====
// top level of the led-64 block decrypt unit: key register and 32 round stages
// depends on led64_pkg and led64_round
//
// channel  direction  handshake              payload
// cfg      in         cfg_valid / cfg_ready  cipher_key
// in       in         in_valid / in_stall    cipher_block
// out      out        out_valid / out_stall  plain_block
//
// one block accepted per cycle unless a waiting output is stalled; each round stage does one round
// the last round stage is the output register
// reset clears the key to zero and every stage valid bit
// a stalled output holding a valid block freezes all stages, and in_stall follows it
// the key is taken at any time but must only change with the pipe empty
`timescale 1ns / 1ps

module led64_block_decrypt_unit
    import led64_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cipher_key,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] cipher_block,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] plain_block
);

    logic [63:0] key_reg;
    logic        en;
    logic        vld   [ROUNDS+1];
    logic [63:0] state [ROUNDS+1];

    // key register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_valid)
        begin
            key_reg <= cipher_key;
        end
    end

    assign cfg_ready = 1'b1;

    // pipe advances unless a finished request waits at the output
    assign en       = !(vld[ROUNDS] && out_stall);
    assign in_stall = !en;

    assign vld[0]   = in_valid;
    assign state[0] = cipher_block;

    // round stages
    for (genvar i = 0; i < ROUNDS; i++)
    begin : g_round
        led64_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .rnd       (5'(i)),
            .key       (key_reg),
            .in_vld    (vld[i]),
            .in_state  (state[i]),
            .out_vld   (vld[i+1]),
            .out_state (state[i+1])
        );
    end

    assign out_valid   = vld[ROUNDS];
    assign plain_block = state[ROUNDS];

endmodule

// ===== hw/rtl/led64_round.sv =====
// one pipeline stage: a single inverse round with its key whitening
// depends on led64_pkg
`timescale 1ns / 1ps

module led64_round
    import led64_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [4:0]  rnd,
    input  logic [63:0] key,
    input  logic        in_vld,
    input  logic [63:0] in_state,
    output logic        out_vld,
    output logic [63:0] out_state
);

    logic        vld_reg;
    logic [63:0] state_reg;
    logic [63:0] state_next;
    logic [63:0] pre;
    logic [63:0] post;

    // initial whitening ahead of round zero, key after every fourth round
    always_comb
    begin
        pre        = (rnd == FIRST_ROUND) ? (in_state ^ key) : in_state;
        post       = inv_round(pre, rnd);
        state_next = (rnd[1:0] == STEP_LAST) ? (post ^ key) : post;
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    // state register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
        end
    end

    assign out_vld   = vld_reg;
    assign out_state = state_reg;

endmodule

// ===== hw/rtl/led64_checker.sv =====
// port-level checks on the led64 block decrypt unit, bound to the top level
// depends on led64_block_decrypt_unit_assert.svh
`timescale 1ns / 1ps
`include "led64_block_decrypt_unit_assert.svh"

module led64_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_stall,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] plain_block
);

    // a waiting result keeps its value
    `LED64_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(plain_block), "output changed while stalled")

    // the input is held up only by a waiting output request
    `LED64_ASSERT_NOW(a_in_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without output backpressure")

    // a result only leaves once it has been taken
    `LED64_ASSERT_NOW(a_out_taken, clk, rst_n, $fell(out_valid), $past(!out_stall), "result dropped before delivery")

endmodule

bind led64_block_decrypt_unit led64_checker u_led64_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .plain_block (plain_block)
);

// ===== tb/sv/led64_block_decrypt_unit_test.sv =====
// self-checking testbench for the led-64 block decrypt unit
// holds its own model of the inverse cipher and compares every plain block
// depends only on led64_block_decrypt_unit and its package
`timescale 1ns / 1ps

module led64_block_decrypt_unit_test;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLDOFF_LEN   = 160;
    localparam int DRAIN_CYCLES  = 40;
    localparam int KEY_SIZE_BITS = 64;

    // key-size constants folded into every round
    localparam logic [3:0] KSIZE_HI = 4'((KEY_SIZE_BITS >> 4) & 15);
    localparam logic [3:0] KSIZE_LO = 4'(KEY_SIZE_BITS & 15);

    localparam logic [3:0] UNSBOX [16] = '{
        4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
        4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
    };

    localparam logic [5:0] LED_RC [32] = '{
        6'h01, 6'h03, 6'h07, 6'h0F, 6'h1F, 6'h3E, 6'h3D, 6'h3B,
        6'h37, 6'h2F, 6'h1E, 6'h3C, 6'h39, 6'h33, 6'h27, 6'h0E,
        6'h1D, 6'h3A, 6'h35, 6'h2B, 6'h16, 6'h2C, 6'h18, 6'h30,
        6'h21, 6'h02, 6'h05, 6'h0B, 6'h17, 6'h2E, 6'h1C, 6'h38
    };

    localparam logic [3:0] UNMIX [4][4] = '{
        '{4'hC, 4'hC, 4'hD, 4'h4},
        '{4'h3, 4'h8, 4'h4, 4'h5},
        '{4'h7, 4'h6, 4'h2, 4'hE},
        '{4'hD, 4'h9, 4'h9, 4'hD}
    };

    // blocks at the edges of the field
    localparam logic [63:0] EDGE_BLOCKS [12] = '{
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
        64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
        64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000,
        64'h0000_0000_8000_0000, 64'h0F0F_0F0F_0F0F_0F0F,
        64'hF000_0000_0000_000F, 64'h7FFF_FFFF_FFFF_FFFE
    };

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [63:0] cipher_key   = '0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [63:0] cipher_block = '0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [63:0] plain_block;

    logic [63:0] block_queue [$];
    logic [63:0] plain_expected [$];
    logic [63:0] key_model = '0;

    int blocks_queued   = 0;
    int blocks_offered  = 0;
    int blocks_accepted = 0;
    int results_checked = 0;
    int keys_written    = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;
    int gap_pct         = 22;
    int stall_pct       = 22;
    int holdoffs_asked  = 0;
    int holdoffs_done   = 0;
    int hold_left       = 0;

    led64_block_decrypt_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cipher_key   (cipher_key),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cipher_block (cipher_block),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .plain_block  (plain_block)
    );

    always #5 clk = ~clk;

    // product of two nibbles in gf(16) modulo x^4+x+1
    function automatic logic [3:0] gf_mul4(input logic [3:0] a, input logic [3:0] b);
        logic [3:0] prod;
        logic [4:0] wide;
        prod = 4'h0;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) begin
                prod = prod ^ a;
            end
            wide = {a, 1'b0};
            if (wide[4]) begin
                wide = wide ^ 5'h13;
            end
            a = wide[3:0];
        end
        return prod;
    endfunction

    // one inverse round, nibble n sits at row n/4, column n%4
    function automatic logic [63:0] led_unround(input logic [63:0] s, input int rnd);
        logic [63:0] t;
        logic [3:0]  acc;
        logic [5:0]  rc;
        int          pos;
        t = '0;
        for (int col = 0; col < 4; col++) begin
            for (int row = 0; row < 4; row++) begin
                acc = 4'h0;
                for (int k = 0; k < 4; k++) begin
                    acc = acc ^ gf_mul4(UNMIX[row][k], s[4*(4*k + col) +: 4]);
                end
                pos = row*4 + ((col + row) % 4);
                t[4*pos +: 4] = acc;
            end
        end
        for (int n = 0; n < 16; n++) begin
            t[4*n +: 4] = UNSBOX[t[4*n +: 4]];
        end
        rc = LED_RC[31 - rnd];
        t[4*0  +: 4] = t[4*0  +: 4] ^ KSIZE_HI;
        t[4*4  +: 4] = t[4*4  +: 4] ^ (4'h1 ^ KSIZE_HI);
        t[4*8  +: 4] = t[4*8  +: 4] ^ (4'h2 ^ KSIZE_LO);
        t[4*12 +: 4] = t[4*12 +: 4] ^ (4'h3 ^ KSIZE_LO);
        t[4*1  +: 4] = t[4*1  +: 4] ^ {1'b0, rc[5:3]};
        t[4*9  +: 4] = t[4*9  +: 4] ^ {1'b0, rc[5:3]};
        t[4*5  +: 4] = t[4*5  +: 4] ^ {1'b0, rc[2:0]};
        t[4*13 +: 4] = t[4*13 +: 4] ^ {1'b0, rc[2:0]};
        return t;
    endfunction

    // full decryption: key whitening, then 8 groups of 4 rounds each closed by the key
    function automatic logic [63:0] led64_decrypt(input logic [63:0] blk, input logic [63:0] k);
        logic [63:0] s;
        s = blk ^ k;
        for (int g = 0; g < 8; g++) begin
            for (int r = 0; r < 4; r++) begin
                s = led_unround(s, g*4 + r);
            end
            s = s ^ k;
        end
        return s;
    endfunction

    // mostly dense random blocks, some with one bit set or cleared
    function automatic logic [63:0] random_block();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(9))
            0: w = 64'h1 << $urandom_range(63);
            1: w = ~(64'h1 << $urandom_range(63));
            default: ;
        endcase
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s got %016h want %016h",
                 cycle_count, what, got, want);
    endtask

    task automatic queue_block(input logic [63:0] blk);
        block_queue.push_back(blk);
        blocks_queued++;
    endtask

    task automatic queue_random_blocks(input int count);
        @(posedge clk);
        for (int i = 0; i < count; i++) begin
            queue_block(random_block());
        end
    endtask

    // wait until every queued request has come back as a plain block
    task automatic wait_for_plain_blocks();
        do @(negedge clk); while (results_checked != blocks_queued);
    endtask

    // key write, only with the pipe empty
    task automatic write_key(input logic [63:0] k);
        int target;
        target = keys_written + 1;
        cfg_valid  <= 1'b1;
        cipher_key <= k;
        do @(negedge clk); while (keys_written != target);
        cfg_valid <= 1'b0;
    endtask

    // run-time limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // sender: hold a request until taken, else offer the next one or idle
    always @(negedge clk) begin
        if (rst_n && blocks_accepted == blocks_offered) begin
            if (block_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
                in_valid     <= 1'b1;
                cipher_block <= block_queue.pop_front();
                blocks_offered++;
            end
            else begin
                in_valid     <= 1'b0;
                cipher_block <= {$urandom, $urandom};
            end
        end
    end

    // receiver: random stalls plus long hold-offs on request
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_left == 0 && holdoffs_asked > holdoffs_done) begin
                hold_left = HOLDOFF_LEN;
                holdoffs_done++;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // monitor: key writes, accepted requests and returned plain blocks
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                key_model = cipher_key;
                keys_written++;
            end
            if (in_valid && !in_stall) begin
                plain_expected.push_back(led64_decrypt(cipher_block, key_model));
                blocks_accepted++;
            end
            if (out_valid && !out_stall) begin
                if (plain_expected.size() == 0) begin
                    report_mismatch("unexpected plain_block", plain_block, '0);
                end
                else begin
                    if (plain_block !== plain_expected[0]) begin
                        report_mismatch("plain_block", plain_block, plain_expected[0]);
                    end
                    void'(plain_expected.pop_front());
                    results_checked++;
                end
            end
        end
    end

    // stimulus phases
    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // edge blocks under the reset key, then under the all-ones key
        @(posedge clk);
        foreach (EDGE_BLOCKS[i]) begin
            queue_block(EDGE_BLOCKS[i]);
        end
        wait_for_plain_blocks();
        write_key('1);
        @(posedge clk);
        foreach (EDGE_BLOCKS[i]) begin
            queue_block(EDGE_BLOCKS[i]);
        end
        wait_for_plain_blocks();

        // random key, sender pauses halfway until the pipe has drained
        write_key({$urandom, $urandom});
        queue_random_blocks(130);
        wait_for_plain_blocks();
        queue_random_blocks(130);
        wait_for_plain_blocks();

        // long stretch with no idling on either side
        gap_pct   = 0;
        stall_pct = 0;
        write_key(64'h5555_5555_5555_5555);
        queue_random_blocks(260);
        wait_for_plain_blocks();

        // receiver holds off while the sender keeps offering
        stall_pct = 22;
        write_key({$urandom, $urandom});
        queue_random_blocks(260);
        holdoffs_asked++;
        wait_for_plain_blocks();

        gap_pct = 22;
        write_key('0);
        queue_random_blocks(260);
        wait_for_plain_blocks();

        write_key(64'hAAAA_AAAA_AAAA_AAAA);
        queue_random_blocks(260);
        wait_for_plain_blocks();

        write_key({$urandom, $urandom});
        queue_random_blocks(250);
        wait_for_plain_blocks();

        // catch any surplus output
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && plain_expected.size() == 0) begin
            $display("status: pass");
        end
        else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/led64_pkg.sv
hw/rtl/led64_round.sv
hw/rtl/led64_block_decrypt_unit.sv
hw/rtl/led64_checker.sv
tb/sv/led64_block_decrypt_unit_test.sv
